FILE: hdl/assert_macros.svh
// Assertion shorthands shared by the deframer modules.
// Each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/tsd_pkg.sv
package tsd_pkg;

    // Length of the text marker name and its byte table
    localparam int MARKER_LEN = 18;

    localparam logic [7:0] MARKER_TAB [64] = '{
        3: 8'h44, 4: 8'h55, 5: 8'h4B, 6: 8'h54, 7: 8'h4F,
        11: 8'h54, 12: 8'h45, 13: 8'h58, 14: 8'h54,
        default: 8'h5F
    };

    localparam logic [7:0] SLASH_CHAR = 8'h2F;
    localparam logic [7:0] NAME_TERM  = 8'h00;

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_TOTAL,
        PH_NAME,
        PH_ESIZE,
        PH_DATA,
        PH_CLOSED
    } phase_t;

    typedef enum logic [2:0] {
        ROLE_COUNT,
        ROLE_TOTAL,
        ROLE_NAME,
        ROLE_NAME_END,
        ROLE_ESIZE,
        ROLE_PAYLOAD,
        ROLE_IGNORED
    } role_t;

    typedef enum logic [1:0] {
        KIND_FILE,
        KIND_DIR,
        KIND_TEXT
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_BAD_COUNT,
        ERR_BAD_TOTAL,
        ERR_EMPTY_NAME,
        ERR_BAD_SIZE
    } err_t;

    typedef struct packed {
        role_t       byte_role;
        logic [7:0]  echo_byte;
        kind_t       element_kind;
        logic        element_done;
        logic        top_level;
        logic [62:0] element_bytes;
        logic        session_start;
        logic [62:0] session_total;
        logic [62:0] session_received;
        logic        session_done;
        err_t        error_code;
    } result_t;

endpackage

FILE: hdl/tsd_in_reg.sv
`include "assert_macros.svh"

module tsd_in_reg import tsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       advance,
    output logic       q_valid,
    output logic [7:0] q_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    // Take a new beat when empty or when the held one moves on
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_valid ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_ready ? valid_next : valid_reg;
        end
    end

    // Capture the byte on accept
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
        end
    end

    assign q_valid = valid_reg;
    assign q_byte  = byte_reg;

    `ASSERT_NEXT(a_in_hold, valid_reg && !advance, valid_reg && $stable(byte_reg),
        "held input byte lost while waiting")

endmodule

FILE: hdl/tsd_core.sv
`include "assert_macros.svh"

module tsd_core import tsd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  logic [7:0] data_byte,
    output result_t    res
);

    phase_t      phase_reg, phase_next;
    logic [63:0] shift_reg, shift_next;
    logic [2:0]  idx_reg, idx_next;
    logic [62:0] remaining_reg, remaining_next;
    logic [62:0] total_decl_reg, total_decl_next;
    logic [62:0] total_rcv_reg, total_rcv_next;
    logic [62:0] size_reg, size_next;
    logic [62:0] left_reg, left_next;
    logic [6:0]  name_len_reg, name_len_next;
    logic        match_reg, match_next;
    logic        slash_reg, slash_next;
    kind_t       kind_reg, kind_next;

    logic [63:0] fv;
    logic        field_last;
    logic        is_text;
    logic        minus_one;
    logic        finish;

    always_comb
    begin
        fv         = {data_byte, shift_reg[63:8]};
        field_last = (idx_reg == 3'd7);
        is_text    = match_reg && (name_len_reg == 7'(MARKER_LEN));
        minus_one  = &fv;
        finish     = 1'b0;

        phase_next      = phase_reg;
        shift_next      = shift_reg;
        idx_next        = idx_reg;
        remaining_next  = remaining_reg;
        total_decl_next = total_decl_reg;
        total_rcv_next  = total_rcv_reg;
        size_next       = size_reg;
        left_next       = left_reg;
        name_len_next   = name_len_reg;
        match_next      = match_reg;
        slash_next      = slash_reg;
        kind_next       = kind_reg;

        res           = '0;
        res.byte_role = ROLE_IGNORED;

        case (phase_reg)
            PH_COUNT:
            begin
                res.byte_role = ROLE_COUNT;
                shift_next    = fv;
                idx_next      = idx_reg + 3'd1;
                if (field_last)
                begin
                    if (fv == 64'd0 || fv[63])
                    begin
                        res.error_code = ERR_BAD_COUNT;
                        phase_next     = PH_CLOSED;
                    end
                    else
                    begin
                        remaining_next = fv[62:0];
                        phase_next     = PH_TOTAL;
                    end
                end
            end
            PH_TOTAL:
            begin
                res.byte_role = ROLE_TOTAL;
                shift_next    = fv;
                idx_next      = idx_reg + 3'd1;
                if (field_last)
                begin
                    if (fv[63])
                    begin
                        res.error_code = ERR_BAD_TOTAL;
                        phase_next     = PH_CLOSED;
                    end
                    else
                    begin
                        total_decl_next   = fv[62:0];
                        res.session_start = 1'b1;
                        name_len_next     = 7'd0;
                        match_next        = 1'b1;
                        slash_next        = 1'b0;
                        phase_next        = PH_NAME;
                    end
                end
            end
            PH_NAME:
            begin
                if (data_byte != NAME_TERM)
                begin
                    res.byte_role = ROLE_NAME;
                    res.echo_byte = data_byte;
                    if (name_len_reg >= 7'(MARKER_LEN)
                        || data_byte != MARKER_TAB[name_len_reg[5:0]])
                    begin
                        match_next = 1'b0;
                    end
                    if (data_byte == SLASH_CHAR)
                    begin
                        slash_next = 1'b1;
                    end
                    // Saturate the name length
                    if (!(&name_len_reg))
                    begin
                        name_len_next = name_len_reg + 7'd1;
                    end
                end
                else
                begin
                    res.byte_role = ROLE_NAME_END;
                    if (name_len_reg == 7'd0)
                    begin
                        res.error_code = ERR_EMPTY_NAME;
                        phase_next     = PH_CLOSED;
                    end
                    else
                    begin
                        phase_next = PH_ESIZE;
                    end
                end
            end
            PH_ESIZE:
            begin
                res.byte_role = ROLE_ESIZE;
                shift_next    = fv;
                idx_next      = idx_reg + 3'd1;
                if (field_last)
                begin
                    if ((fv[63] && !minus_one) || (is_text && minus_one))
                    begin
                        res.error_code = ERR_BAD_SIZE;
                        phase_next     = PH_CLOSED;
                    end
                    else if (minus_one)
                    begin
                        kind_next = KIND_DIR;
                        size_next = 63'd0;
                        finish    = 1'b1;
                    end
                    else
                    begin
                        kind_next = is_text ? KIND_TEXT : KIND_FILE;
                        size_next = fv[62:0];
                        left_next = fv[62:0];
                        if (fv == 64'd0)
                        begin
                            finish = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_DATA;
                        end
                    end
                end
            end
            PH_DATA:
            begin
                res.byte_role  = ROLE_PAYLOAD;
                res.echo_byte  = data_byte;
                total_rcv_next = total_rcv_reg + 63'd1;
                left_next      = left_reg - 63'd1;
                if (left_reg == 63'd1)
                begin
                    finish = 1'b1;
                end
            end
            PH_CLOSED:
            begin
                res.byte_role = ROLE_IGNORED;
            end
            default:
            begin
                phase_next = PH_CLOSED;
            end
        endcase

        // Close out an element: end the session or open the next name
        if (finish)
        begin
            res.element_done = 1'b1;
            res.top_level    = !slash_reg;
            if (remaining_reg == 63'd1)
            begin
                res.session_done = 1'b1;
                phase_next       = PH_CLOSED;
            end
            else
            begin
                remaining_next = remaining_reg - 63'd1;
                name_len_next  = 7'd0;
                match_next     = 1'b1;
                slash_next     = 1'b0;
                phase_next     = PH_NAME;
            end
        end

        res.element_kind     = kind_next;
        res.element_bytes    = size_next;
        res.session_total    = total_decl_next;
        res.session_received = total_rcv_next;
    end

    // Advance parser state once per beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_COUNT;
            idx_reg        <= 3'd0;
            remaining_reg  <= 63'd0;
            total_decl_reg <= 63'd0;
            total_rcv_reg  <= 63'd0;
            size_reg       <= 63'd0;
            left_reg       <= 63'd0;
            name_len_reg   <= 7'd0;
            match_reg      <= 1'b1;
            slash_reg      <= 1'b0;
            kind_reg       <= KIND_FILE;
        end
        else if (advance)
        begin
            phase_reg      <= phase_next;
            idx_reg        <= idx_next;
            remaining_reg  <= remaining_next;
            total_decl_reg <= total_decl_next;
            total_rcv_reg  <= total_rcv_next;
            size_reg       <= size_next;
            left_reg       <= left_next;
            name_len_reg   <= name_len_next;
            match_reg      <= match_next;
            slash_reg      <= slash_next;
            kind_reg       <= kind_next;
        end
    end

    // Shift field bytes in, low byte first
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            shift_reg <= shift_next;
        end
    end

    `ASSERT_NEXT(a_err_closes, advance && res.error_code != ERR_NONE,
        phase_reg == PH_CLOSED, "error did not close the session")
    `ASSERT_NEXT(a_closed_sticks, phase_reg == PH_CLOSED, phase_reg == PH_CLOSED,
        "closed session reopened")
    `ASSERT_IMPL(a_sdone_done, res.session_done, res.element_done,
        "session end without element end")

endmodule

FILE: hdl/tsd_out_reg.sv
`include "assert_macros.svh"

module tsd_out_reg import tsd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t res_in,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t res_out
);

    logic    valid_reg;
    result_t res_reg;

    // Room for a new result when empty or being drained
    assign space = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (space)
        begin
            valid_reg <= load;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    `ASSERT_IMPL(a_done_role, valid_reg && res_reg.element_done,
        res_reg.byte_role == ROLE_ESIZE || res_reg.byte_role == ROLE_PAYLOAD,
        "element end on a byte that cannot end one")

endmodule

FILE: hdl/transfer_session_deframer.sv
// Channel | Handshake            | Payload
// --------+----------------------+------------------------------------------
// input   | in_valid / in_ready  | data_byte
// output  | out_valid / out_ready| byte_role .. error_code (one result/beat)
//
// One byte per cycle while out_ready is high; in_reg, core, then out_reg.
// The per-byte step is one pass of compares, a shift and 63-bit counters.
// Reset (rst_n low, asynchronous) empties both stages and reopens the parser.
// With out_ready low the result holds and one more byte is buffered at input.

module transfer_session_deframer import tsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  byte_role,
    output logic [7:0]  echo_byte,
    output logic [1:0]  element_kind,
    output logic        element_done,
    output logic        top_level,
    output logic [62:0] element_bytes,
    output logic        session_start,
    output logic [62:0] session_total,
    output logic [62:0] session_received,
    output logic        session_done,
    output logic [2:0]  error_code
);

    logic       q_valid;
    logic [7:0] q_byte;
    logic       space;
    logic       advance;
    result_t    step_res;
    result_t    out_res;

    // Move a beat through the parser when the result stage has room
    assign advance = q_valid && space;

    tsd_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .advance   (advance),
        .q_valid   (q_valid),
        .q_byte    (q_byte)
    );

    tsd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .data_byte (q_byte),
        .res       (step_res)
    );

    tsd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_in    (step_res),
        .space     (space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_out   (out_res)
    );

    assign byte_role        = out_res.byte_role;
    assign echo_byte        = out_res.echo_byte;
    assign element_kind     = out_res.element_kind;
    assign element_done     = out_res.element_done;
    assign top_level        = out_res.top_level;
    assign element_bytes    = out_res.element_bytes;
    assign session_start    = out_res.session_start;
    assign session_total    = out_res.session_total;
    assign session_received = out_res.session_received;
    assign session_done     = out_res.session_done;
    assign error_code       = out_res.error_code;

endmodule
